@@ hw/rtl/tpnu_pkg.sv @@
// tpnu_pkg: shared types, register indexes and microprogram for the triclinic unwrap block
// no dependencies; imported by triclinic_pbc_nojump_unwrap
package tpnu_pkg;

	// default values of the top level parameters
	localparam int MAX_SHIFTS_DEF  = 8;
	localparam int COORD_WIDTH_DEF = 32;

	// configuration register indexes, also used as box entry selectors
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_BOX_XX = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BOX_YX = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BOX_YY = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BOX_ZX = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BOX_ZY = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BOX_ZZ = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SCALE  = 3'd6;
	localparam int NUM_BOX = 6;

	// coordinate selectors
	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	// microprogram step counter
	localparam int STEP_W = 5;

	typedef enum logic [2:0] {
		OP_NOP  = 3'd0,  // wait for the scaled box
		OP_CHKZ = 3'd1,  // skip the dimension on a zero diagonal, clear count
		OP_TNEG = 3'd2,  // test for an add correction
		OP_TPOS = 3'd3,  // test for a subtract correction
		OP_ADD  = 3'd4,  // add one box entry to one coordinate
		OP_SUB  = 3'd5,  // subtract one box entry from one coordinate
		OP_DONE = 3'd6   // hand the result to the output register
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [1:0]           coord;
		logic [REG_IDX_W-1:0] bidx;
		logic                 last;
		logic [STEP_W-1:0]    target;
	} ctrl_t;

	function automatic ctrl_t cw(input op_t op, input logic [1:0] coord,
			input logic [REG_IDX_W-1:0] bidx, input logic last,
			input logic [STEP_W-1:0] target);
		ctrl_t c;
		c.op     = op;
		c.coord  = coord;
		c.bidx   = bidx;
		c.last   = last;
		c.target = target;
		return c;
	endfunction

	// control store: dimensions z, y, x; a test jumps to target when it fails or the shift count
	// is full, the last update of a correction jumps back to its test
	function automatic ctrl_t prog_rom(input logic [STEP_W-1:0] s);
		ctrl_t c;
		case (s)
			5'd0:    c = cw(OP_NOP,  AX_X, REG_BOX_XX, 1'b0, 5'd0);
			// z dimension
			5'd1:    c = cw(OP_CHKZ, AX_Z, REG_BOX_ZZ, 1'b0, 5'd10);
			5'd2:    c = cw(OP_TNEG, AX_Z, REG_BOX_ZZ, 1'b0, 5'd6);
			5'd3:    c = cw(OP_ADD,  AX_X, REG_BOX_ZX, 1'b0, 5'd0);
			5'd4:    c = cw(OP_ADD,  AX_Y, REG_BOX_ZY, 1'b0, 5'd0);
			5'd5:    c = cw(OP_ADD,  AX_Z, REG_BOX_ZZ, 1'b1, 5'd2);
			5'd6:    c = cw(OP_TPOS, AX_Z, REG_BOX_ZZ, 1'b0, 5'd10);
			5'd7:    c = cw(OP_SUB,  AX_X, REG_BOX_ZX, 1'b0, 5'd0);
			5'd8:    c = cw(OP_SUB,  AX_Y, REG_BOX_ZY, 1'b0, 5'd0);
			5'd9:    c = cw(OP_SUB,  AX_Z, REG_BOX_ZZ, 1'b1, 5'd6);
			// y dimension
			5'd10:   c = cw(OP_CHKZ, AX_Y, REG_BOX_YY, 1'b0, 5'd17);
			5'd11:   c = cw(OP_TNEG, AX_Y, REG_BOX_YY, 1'b0, 5'd14);
			5'd12:   c = cw(OP_ADD,  AX_X, REG_BOX_YX, 1'b0, 5'd0);
			5'd13:   c = cw(OP_ADD,  AX_Y, REG_BOX_YY, 1'b1, 5'd11);
			5'd14:   c = cw(OP_TPOS, AX_Y, REG_BOX_YY, 1'b0, 5'd17);
			5'd15:   c = cw(OP_SUB,  AX_X, REG_BOX_YX, 1'b0, 5'd0);
			5'd16:   c = cw(OP_SUB,  AX_Y, REG_BOX_YY, 1'b1, 5'd14);
			// x dimension
			5'd17:   c = cw(OP_CHKZ, AX_X, REG_BOX_XX, 1'b0, 5'd22);
			5'd18:   c = cw(OP_TNEG, AX_X, REG_BOX_XX, 1'b0, 5'd20);
			5'd19:   c = cw(OP_ADD,  AX_X, REG_BOX_XX, 1'b1, 5'd18);
			5'd20:   c = cw(OP_TPOS, AX_X, REG_BOX_XX, 1'b0, 5'd22);
			5'd21:   c = cw(OP_SUB,  AX_X, REG_BOX_XX, 1'b1, 5'd20);
			default: c = cw(OP_DONE, AX_X, REG_BOX_XX, 1'b0, 5'd0);
		endcase
		return c;
	endfunction

	// box entry times ten when scaling is on, saturated to 32 bits
	function automatic logic [31:0] scale_entry(input logic [31:0] v, input logic scale);
		logic signed [35:0] x;
		logic signed [35:0] p;
		logic [31:0]        r;
		x = {{4{v[31]}}, v};
		p = (x <<< 3) + (x <<< 1);
		if (!scale)
			r = v;
		else if (p[35:31] == {5{p[35]}})
			r = p[31:0];
		else
			r = p[35] ? 32'h8000_0000 : 32'h7fff_ffff;
		return r;
	endfunction

endpackage

@@ hw/rtl/triclinic_pbc_nojump_unwrap.sv @@
// triclinic_pbc_nojump_unwrap: restores an atom to the periodic image nearest its reference
// microcoded sequencer over one shared add/compare datapath; depends on tpnu_pkg
// sequencing: a step counter walks the control store over the single adder, each correction
//   of a dimension adds steps to it, and a zero diagonal cuts its dimension short
// throughput: one item at a time; the next item is taken the cycle after the result is loaded
// reset: arst_n clears the box registers, scale mode, sequencer and output valid
module triclinic_pbc_nojump_unwrap #(
	parameter int MAX_SHIFTS  = tpnu_pkg::MAX_SHIFTS_DEF,
	parameter int COORD_WIDTH = tpnu_pkg::COORD_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration writes
	input  logic                           cfg_we,
	input  logic [tpnu_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_wdata,
	// input beats
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [191:0]                   s_tdata,  // pos_x, pos_y, pos_z, ref_x, ref_y, ref_z
	// result beats
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [103:0]                   m_tdata   // out_x, out_y, out_z, moved, shift_cap_hit, pad
);
	import tpnu_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int XW    = ((CW > 32) ? CW : 32) + 3;
	localparam int CNT_W = $clog2(MAX_SHIFTS + 1);

	// saturate a wide value into the coordinate range
	function automatic logic signed [CW-1:0] sat_cw(input logic signed [XW-1:0] v);
		logic signed [CW-1:0] r;
		if (v[XW-1:CW-1] == {(XW-CW+1){v[XW-1]}})
			r = v[CW-1:0];
		else
			r = v[XW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		return r;
	endfunction

	function automatic logic signed [XW-1:0] ext_cw(input logic signed [CW-1:0] v);
		return {{(XW-CW){v[CW-1]}}, v};
	endfunction

	function automatic logic signed [XW-1:0] ext_32(input logic [31:0] v);
		return {{(XW-32){v[31]}}, v};
	endfunction

	// configuration and scaled box
	logic [31:0]             box_q     [NUM_BOX];
	logic [31:0]             box_eff_q [NUM_BOX];
	logic                    scale_q;

	// sequencer and datapath registers
	logic                    busy_q;
	logic [STEP_W-1:0]       step_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [CW-1:0]    a_q [3];
	logic [31:0]             r_q [3];
	logic                    moved_q;
	logic                    cap_q;

	// output register
	logic                    m_tvalid_q;
	logic [31:0]             out_x_q, out_y_q, out_z_q;
	logic                    out_moved_q, out_cap_q;

	// datapath signals
	ctrl_t                   ctrl;
	logic signed [XW-1:0]    ax, rx, bx, diff2, upd;
	logic signed [XW-1:0]    ext_x, ext_y, ext_z;
	logic                    cond_neg, cond_pos, diag_zero, cnt_full, in_beat, out_free;
	logic                    out_load;
	logic signed [CW-1:0]    new_coord;

	assign s_tready = !busy_q;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, out_cap_q, out_moved_q, out_z_q, out_y_q, out_x_q};
	assign in_beat  = s_tvalid && !busy_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = busy_q && (ctrl.op == OP_DONE) && out_free;

	// control word decode and the shared add/compare unit
	always_comb begin
		ctrl      = prog_rom(step_q);
		ax        = ext_cw(a_q[ctrl.coord]);
		rx        = ext_32(r_q[ctrl.coord]);
		bx        = ext_32(box_eff_q[ctrl.bidx]);
		diff2     = (ax - rx) <<< 1;
		cond_neg  = (diff2 <= -bx);
		cond_pos  = (diff2 > bx);
		diag_zero = (bx == '0);
		cnt_full  = (cnt_q == CNT_W'(MAX_SHIFTS));
		upd       = (ctrl.op == OP_SUB) ? (ax - bx) : (ax + bx);
		new_coord = sat_cw(upd);
		ext_x     = ext_cw(a_q[0]);
		ext_y     = ext_cw(a_q[1]);
		ext_z     = ext_cw(a_q[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BOX; i++) begin
				box_q[i]     <= '0;
				box_eff_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) begin
				a_q[i] <= '0;
				r_q[i] <= '0;
			end
			scale_q     <= 1'b0;
			busy_q      <= 1'b0;
			step_q      <= '0;
			cnt_q       <= '0;
			moved_q     <= 1'b0;
			cap_q       <= 1'b0;
			m_tvalid_q  <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_z_q     <= '0;
			out_moved_q <= 1'b0;
			out_cap_q   <= 1'b0;
		end else begin
			// register writes
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BOX_XX: box_q[0] <= cfg_wdata;
					REG_BOX_YX: box_q[1] <= cfg_wdata;
					REG_BOX_YY: box_q[2] <= cfg_wdata;
					REG_BOX_ZX: box_q[3] <= cfg_wdata;
					REG_BOX_ZY: box_q[4] <= cfg_wdata;
					REG_BOX_ZZ: box_q[5] <= cfg_wdata;
					REG_SCALE:  scale_q  <= cfg_wdata[0];
					default: ;
				endcase
			end

			// scaled box follows the registers in the next cycle
			for (int i = 0; i < NUM_BOX; i++)
				box_eff_q[i] <= scale_entry(box_q[i], scale_q);

			// result loaded or taken
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;

			if (in_beat) begin
				// load one atom, coordinates clamped into range
				a_q[0]  <= sat_cw(ext_32(s_tdata[31:0]));
				a_q[1]  <= sat_cw(ext_32(s_tdata[63:32]));
				a_q[2]  <= sat_cw(ext_32(s_tdata[95:64]));
				r_q[0]  <= s_tdata[127:96];
				r_q[1]  <= s_tdata[159:128];
				r_q[2]  <= s_tdata[191:160];
				moved_q <= 1'b0;
				cap_q   <= 1'b0;
				cnt_q   <= '0;
				step_q  <= '0;
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				// execute one control word
				unique case (ctrl.op) inside
					OP_NOP: begin
						step_q <= step_q + STEP_W'(1);
					end
					OP_CHKZ: begin
						cnt_q  <= '0;
						step_q <= diag_zero ? ctrl.target : step_q + STEP_W'(1);
					end
					OP_TNEG, OP_TPOS: begin
						if (cnt_full) begin
							cap_q  <= 1'b1;
							cnt_q  <= '0;
							step_q <= ctrl.target;
						end else if ((ctrl.op == OP_TNEG) ? cond_neg : cond_pos) begin
							step_q <= step_q + STEP_W'(1);
						end else begin
							cnt_q  <= '0;
							step_q <= ctrl.target;
						end
					end
					OP_ADD, OP_SUB: begin
						a_q[ctrl.coord] <= new_coord;
						moved_q         <= 1'b1;
						if (ctrl.last) begin
							cnt_q  <= cnt_q + CNT_W'(1);
							step_q <= ctrl.target;
						end else begin
							step_q <= step_q + STEP_W'(1);
						end
					end
					OP_DONE: begin
						if (out_free) begin
							out_x_q     <= ext_x[31:0];
							out_y_q     <= ext_y[31:0];
							out_z_q     <= ext_z[31:0];
							out_moved_q <= moved_q;
							out_cap_q   <= cap_q;
							busy_q      <= 1'b0;
						end
					end
					default: begin
						busy_q <= 1'b0;
					end
				endcase
			end
		end
	end

endmodule
